// ===== design/signed_integer_to_radix_digits_core_defines.svh =====
// Assertion macros shared by the radix digit converter RTL.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked assertion that is switched off while reset is high.
`define SIRD_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define SIRD_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SIRD_ASSERT(label, clock, reset, prop, msg)
`define SIRD_ASSERT_ALWAYS(label, clock, prop, msg)
`endif

`endif

// ===== design/sird_pkg.sv =====
// Types and constants shared by the radix digit converter modules.
`default_nettype none

package sird_pkg;

  // Character constants used by the alphabet check and the sign output.
  localparam logic [7:0] MINUS_CHAR     = 8'h2D;
  localparam logic [7:0] PLUS_CHAR      = 8'h2B;
  localparam logic [7:0] PRINTABLE_LOW  = 8'd32;
  localparam logic [7:0] PRINTABLE_HIGH = 8'd126;

  // Alphabet storage and divider step count.
  localparam int NUM_SYMBOLS = 16;
  localparam int DIV_STEPS   = 8;

  // Configuration register indexes.
  localparam logic [1:0] REG_RADIX        = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_STORE,
    ST_SIGN,
    ST_READ,
    ST_PUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_next;
    logic div_step;
    logic store;
    logic idx_dec;
    logic out_sign;
    logic out_digit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alpha_ok;
    logic div_last;
    logic conv_done;
    logic neg;
    logic idx_zero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== design/signed_integer_to_radix_digits_core.sv =====
// Top level of the signed integer to radix digit text converter.
// Converts one signed value per input transaction into its text in the configured
// radix (2 to MAX_RADIX), most significant digit first, with a leading minus for
// negative values; the last character carries final_char. An invalid alphabet gives
// no output at all. The divider retires eight dividend bits per cycle, and the digit
// buffer has a registered read. Input is taken only between conversions; the last
// character may still wait in the output register.
`default_nettype none

module signed_integer_to_radix_digits_core
  import sird_pkg::*;
#(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [63:0]                  cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [VALUE_BITS-1:0] value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        character,
  output logic                              final_char
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  sird_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Registers, divider, digit buffer and output stage.
  sird_dp #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .character  (character),
    .final_char (final_char),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

`default_nettype wire

// ===== design/sird_ctrl.sv =====
// Controller state machine of the radix digit converter.
`default_nettype none

module sird_ctrl
  import sird_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // An invalid alphabet drops the transaction without output.
        if (status.alpha_ok) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (status.conv_done) begin
          state_next = ST_SIGN;
        end else begin
          cmd.div_next = 1'b1;
          state_next   = ST_DIV;
        end
      end
      ST_SIGN: begin
        if (!status.neg) begin
          state_next = ST_READ;
        end else if (status.out_free) begin
          cmd.out_sign = 1'b1;
          state_next   = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_PUT;
      end
      ST_PUT: begin
        if (status.out_free) begin
          cmd.out_digit = 1'b1;
          if (status.idx_zero) begin
            state_next = ST_IDLE;
          end else begin
            cmd.idx_dec = 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sird_dp.sv =====
// Datapath of the radix digit converter: registers, divider, digit buffer, output.
`default_nettype none
`include "signed_integer_to_radix_digits_core_defines.svh"

module sird_dp
  import sird_pkg::*;
#(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [63:0]                  cfg_data,
  input  wire logic signed [VALUE_BITS-1:0] value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        character,
  output logic                              final_char,
  input  wire cmd_t                         cmd,
  output status_t                           status
);

  localparam int CHUNKS = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PW     = CHUNKS * DIV_STEPS;
  localparam int CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int AW     = $clog2(VALUE_BITS);
  localparam int CW     = $clog2(VALUE_BITS + 1);

  // Configuration registers.
  logic [4:0]                   radix;
  logic [63:0]                  symbols_low;
  logic [63:0]                  symbols_high;
  logic [8*NUM_SYMBOLS-1:0]     syms;
  logic                         alpha_ok;
  logic                         alpha_ok_comb;
  logic [7:0]                   sym_a;

  // Conversion state.
  logic                         neg;
  logic [VALUE_BITS-1:0]        mag;
  logic [PW-1:0]                work;
  logic [PW-1:0]                work_step;
  logic [3:0]                   rem;
  logic [3:0]                   rem_step;
  logic [4:0]                   trial;
  logic [CHW-1:0]               chunk;
  logic [CW-1:0]                count;
  logic [AW-1:0]                idx;
  logic [3:0]                   digit_mem [VALUE_BITS];
  logic [3:0]                   rd_data;
  logic                         out_free;

  assign syms = {symbols_high, symbols_low};

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIX:        radix        <= cfg_data[4:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Alphabet check: radix range, printable symbols without signs, no duplicates.
  always_comb begin
    alpha_ok_comb = (radix >= 5'd2) && (radix <= 5'(MAX_RADIX));
    sym_a = '0;
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      sym_a = syms[i*8 +: 8];
      if (5'(i) < radix) begin
        if (sym_a == MINUS_CHAR || sym_a == PLUS_CHAR ||
            sym_a < PRINTABLE_LOW || sym_a > PRINTABLE_HIGH) begin
          alpha_ok_comb = 1'b0;
        end
        for (int j = i + 1; j < NUM_SYMBOLS; j++) begin
          if (5'(j) < radix && syms[j*8 +: 8] == sym_a) begin
            alpha_ok_comb = 1'b0;
          end
        end
      end
    end
  end

  // The check result is registered; it is consulted in the cycle after acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_ok <= 1'b0;
    end else begin
      alpha_ok <= alpha_ok_comb;
    end
  end

  // Eight restoring division steps per cycle, dividend bits MSB first.
  always_comb begin
    work_step = work;
    rem_step  = rem;
    trial     = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial     = {rem_step, work_step[PW-1]};
      work_step = {work_step[PW-2:0], 1'b0};
      if (trial >= radix) begin
        trial        = trial - radix;
        work_step[0] = 1'b1;
      end
      rem_step = trial[3:0];
    end
  end

  // Input capture: sign and unsigned magnitude.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[VALUE_BITS-1];
      mag <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
    end
  end

  // Divider registers: the work word becomes the quotient after all chunks.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      work  <= PW'(mag);
      rem   <= '0;
      chunk <= '0;
    end else if (cmd.div_next) begin
      rem   <= '0;
      chunk <= '0;
    end else if (cmd.div_step) begin
      work  <= work_step;
      rem   <= rem_step;
      chunk <= chunk + 1'b1;
    end
  end

  // Digit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.div_start) begin
      count <= '0;
    end else if (cmd.store) begin
      count <= count + 1'b1;
    end
  end

  // Read pointer: starts on the most significant digit just stored.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      idx <= count[AW-1:0];
    end else if (cmd.idx_dec) begin
      idx <= idx - 1'b1;
    end
  end

  // Digit buffer, least significant digit at address zero.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      digit_mem[count[AW-1:0]] <= rem;
    end
    rd_data <= digit_mem[idx];
  end

  assign out_free = !out_valid || out_ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_sign || cmd.out_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_sign) begin
      character  <= MINUS_CHAR;
      final_char <= 1'b0;
    end else if (cmd.out_digit) begin
      character  <= syms[{rd_data, 3'b000} +: 8];
      final_char <= (idx == '0);
    end
  end

  // Status to the controller.
  always_comb begin
    status.alpha_ok  = alpha_ok;
    status.div_last  = (chunk == CHW'(CHUNKS - 1));
    status.conv_done = (work == '0) || (count == CW'(VALUE_BITS - 1));
    status.neg       = neg;
    status.idx_zero  = (idx == '0);
    status.out_free  = out_free;
  end

  // A stored digit always lies below the radix and inside the buffer.
  `SIRD_ASSERT(a_digit_range, clk, rst, cmd.store |-> ({1'b0, rem} < radix), "digit not below radix")
  `SIRD_ASSERT(a_store_bound, clk, rst, cmd.store |-> (count < CW'(VALUE_BITS)), "buffer overrun")
  // The output register is loaded only when its transaction has gone or goes now.
  `SIRD_ASSERT(a_out_free, clk, rst, (cmd.out_sign || cmd.out_digit) |-> out_free, "output overwritten")
  // A new conversion starts with an empty digit count.
  `SIRD_ASSERT(a_start_clear, clk, rst, cmd.div_start |=> (count == '0), "count not cleared")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the signed integer to radix digit text converter.
`timescale 1ns / 100ps

module tb_top;
  import sird_pkg::*;

  localparam int MAX_RADIX  = 16;
  localparam int VALUE_BITS = 32;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES   = 300;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int TOTAL_ITEMS     = 120;

  // Digits 0 to 9 in order; the unused upper slots hold bytes that would be illegal.
  localparam logic [127:0] DECIMAL_SYMBOLS = {48'hFFFF_2B2D_1F7F, "98", "76543210"};
  // Sixteen symbols with space as digit 0 and tilde as digit 15.
  localparam logic [127:0] HEX_EDGE_SYMBOLS = {"~EDCBA98", "7654321 "};
  // Binary digits with junk in every unused slot.
  localparam logic [127:0] BINARY_SYMBOLS = {64'hFFFF_FFFF_FFFF_FFFF, 48'h2D2B_001F_7F80, "10"};

  // Predicts the text of each accepted number and checks the characters as they arrive.
  class radix_text_scoreboard;
    typedef struct packed {
      logic [7:0] character;
      logic       final_char;
    } text_char_t;

    logic [4:0]  radix;
    logic [63:0] symbols_low;
    logic [63:0] symbols_high;
    text_char_t  expected_text[$];
    int          errors;

    function new();
      radix        = '0;
      symbols_low  = '0;
      symbols_high = '0;
      errors       = 0;
    endfunction

    // Mirrors a register write; the unused index is dropped.
    function void write_reg(logic [1:0] index, logic [63:0] data);
      case (index)
        REG_RADIX:        radix = data[4:0];
        REG_SYMBOLS_LOW:  symbols_low = data;
        REG_SYMBOLS_HIGH: symbols_high = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] symbol_of(int k);
      return (k < 8) ? symbols_low[k*8 +: 8] : symbols_high[(k-8)*8 +: 8];
    endfunction

    // Only the first radix symbols matter; each must be printable, unsigned and unique.
    function bit alphabet_valid();
      logic [7:0] s;
      if (radix < 2 || radix > MAX_RADIX)
        return 1'b0;
      for (int i = 0; i < radix; i++) begin
        s = symbol_of(i);
        if (s == MINUS_CHAR || s == PLUS_CHAR || s < PRINTABLE_LOW || s > PRINTABLE_HIGH)
          return 1'b0;
        for (int j = i + 1; j < radix; j++)
          if (symbol_of(j) == s)
            return 1'b0;
      end
      return 1'b1;
    endfunction

    // Queues the characters that one accepted number must produce.
    function void note_value(logic signed [VALUE_BITS-1:0] v);
      logic [VALUE_BITS-1:0] magnitude;
      logic [3:0]            digits[$];
      text_char_t            t;
      if (!alphabet_valid())
        return;
      magnitude = v;
      if (v[VALUE_BITS-1]) begin
        // Unsigned negation keeps the most negative value exact.
        magnitude    = -magnitude;
        t.character  = MINUS_CHAR;
        t.final_char = 1'b0;
        expected_text.push_back(t);
      end
      do begin
        digits.push_front(4'(magnitude % radix));
        magnitude = magnitude / radix;
      end while (magnitude != 0);
      foreach (digits[k]) begin
        t.character  = symbol_of(digits[k]);
        t.final_char = (k == digits.size() - 1);
        expected_text.push_back(t);
      end
    endfunction

    // Compares one received character with the oldest one still owed.
    function void check_char(logic [7:0] ch, logic fin);
      text_char_t want;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, got %h final %b", $time, ch, fin);
        errors++;
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.character) begin
        $display("%0t: character mismatch: expected %h, got %h", $time, want.character, ch);
        errors++;
      end
      if (fin !== want.final_char) begin
        $display("%0t: final_char mismatch: expected %b, got %b", $time, want.final_char, fin);
        errors++;
      end
    endfunction

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_write;
  logic [1:0]                   cfg_index;
  logic [63:0]                  cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         out_valid;
  logic                         out_ready;
  logic [7:0]                   character;
  logic                         final_char;

  radix_text_scoreboard text_check = new();
  bit                   hold_output = 1'b0;
  int                   quiet_cycles = 0;
  int                   sent_items = 0;

  always #2 clk = ~clk;

  signed_integer_to_radix_digits_core #(
    .MAX_RADIX (MAX_RADIX),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .final_char(final_char)
  );

  // Holds cfg_write high; the caller lowers it after its last write.
  task automatic write_reg(input logic [1:0] index, input logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    text_check.write_reg(index, data);
  endtask

  // Writes all registers, with random junk above the radix field and to the unused index.
  task automatic load_alphabet(input logic [4:0] r, input logic [127:0] syms);
    logic [63:0] radix_word;
    radix_word      = {$urandom, $urandom};
    radix_word[4:0] = r;
    write_reg(REG_RADIX, radix_word);
    write_reg(REG_SYMBOLS_LOW, syms[63:0]);
    write_reg(REG_SYMBOLS_HIGH, syms[127:64]);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    cfg_write <= 1'b0;
  endtask

  // Offers one number after an optional gap and returns once the transaction is taken.
  task automatic send_value(input logic signed [VALUE_BITS-1:0] v, input bit gapless);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    text_check.note_value(v);
    sent_items++;
  endtask

  // Waits for all owed text, then lets a silent conversion run out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (text_check.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // An invalid alphabet must swallow the number without any text.
  task automatic check_rejected(input logic [4:0] r, input logic [127:0] syms);
    load_alphabet(r, syms);
    send_value($urandom, 1'b0);
    wait_drained();
  endtask

  function automatic logic signed [VALUE_BITS-1:0] random_value();
    logic signed [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 300);
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = 32'sh8000_0001;
          3: v = 32'sd0;
          default: v = 32'sd1;
        endcase
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) == 1 && v != 32'sh8000_0000)
      v = -v;
    return v;
  endfunction

  // Distinct legal symbols in the first r slots, anything at all above them.
  function automatic logic [127:0] random_alphabet(int r);
    logic [7:0]   pool[$];
    logic [127:0] syms;
    int           pick;
    for (int c = PRINTABLE_LOW; c <= PRINTABLE_HIGH; c++)
      if (c != MINUS_CHAR && c != PLUS_CHAR)
        pool.push_back(8'(c));
    syms = {$urandom, $urandom, $urandom, $urandom};
    for (int k = 0; k < r; k++) begin
      pick = $urandom_range(0, pool.size() - 1);
      syms[k*8 +: 8] = pool[pick];
      pool.delete(pick);
    end
    return syms;
  endfunction

  // Breaks one used slot, either with an illegal byte or a copy of another slot.
  function automatic logic [127:0] spoil_alphabet(logic [127:0] syms, int r, bit duplicate);
    int         i;
    int         j;
    logic [7:0] bad;
    i = $urandom_range(0, r - 1);
    if (duplicate) begin
      j = $urandom_range(0, r - 2);
      if (j >= i)
        j++;
      syms[i*8 +: 8] = syms[j*8 +: 8];
    end else begin
      case ($urandom_range(0, 3))
        0: bad = MINUS_CHAR;
        1: bad = PLUS_CHAR;
        2: bad = 8'($urandom_range(0, 31));
        default: bad = 8'($urandom_range(127, 255));
      endcase
      syms[i*8 +: 8] = bad;
    end
    return syms;
  endfunction

  task automatic run_phase(input logic [4:0] r, input logic [127:0] syms, input int count,
                           input bit gapless);
    load_alphabet(r, syms);
    repeat (count) send_value(random_value(), gapless);
    wait_drained();
  endtask

  // Result side: random stalls, bursts with none, and one long hold on request.
  initial begin : result_sink
    int stall;
    int burst;
    burst = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
      if (burst == 0 && $urandom_range(0, 15) == 0)
        burst = $urandom_range(10, 40);
      if (burst > 0) begin
        stall = 0;
        burst--;
      end else begin
        stall = $urandom_range(0, 12);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      text_check.check_char(character, final_char);
    end
  end

  // Ends the run if neither side moves a transaction for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [127:0] syms;
    int           r;
    int           n;

    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    value     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight out of reset the radix is zero, so nothing may come out.
    send_value(32'sd5, 1'b0);
    wait_drained();

    // Decimal: zero, single digits, a digit carry, both signs and both extremes.
    load_alphabet(5'd10, DECIMAL_SYMBOLS);
    send_value(32'sd0, 1'b0);
    send_value(32'sd1, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd9, 1'b0);
    send_value(32'sd10, 1'b0);
    send_value(-32'sd10, 1'b0);
    send_value(32'sh7FFF_FFFF, 1'b0);
    send_value(32'sh8000_0000, 1'b0);
    wait_drained();

    // Full sixteen symbols with the printable boundaries used as digits.
    load_alphabet(5'd16, HEX_EDGE_SYMBOLS);
    send_value(32'sh7FFF_FFFF, 1'b0);
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'shFFFF_FFFF, 1'b0);
    send_value(32'shDEAD_BEEF, 1'b0);
    wait_drained();

    // Binary gives the longest text: a sign and 32 digits for the most negative value.
    load_alphabet(5'd2, BINARY_SYMBOLS);
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sh7FFF_FFFF, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    wait_drained();

    // Radix out of range on both sides.
    check_rejected(5'd1, DECIMAL_SYMBOLS);
    check_rejected(5'd17, DECIMAL_SYMBOLS);
    check_rejected(5'd31, DECIMAL_SYMBOLS);

    // Sign characters, bytes just outside the printable range, and a repeated symbol.
    syms = DECIMAL_SYMBOLS;
    syms[3*8 +: 8] = PLUS_CHAR;
    check_rejected(5'd10, syms);
    syms = DECIMAL_SYMBOLS;
    syms[7*8 +: 8] = MINUS_CHAR;
    check_rejected(5'd10, syms);
    syms = DECIMAL_SYMBOLS;
    syms[0 +: 8] = PRINTABLE_LOW - 8'd1;
    check_rejected(5'd10, syms);
    syms = DECIMAL_SYMBOLS;
    syms[9*8 +: 8] = PRINTABLE_HIGH + 8'd1;
    check_rejected(5'd10, syms);
    syms = DECIMAL_SYMBOLS;
    syms[9*8 +: 8] = syms[2*8 +: 8];
    check_rejected(5'd10, syms);

    // Back-to-back numbers while the output is held, so the input has to stall.
    hold_output = 1'b1;
    run_phase(5'd10, DECIMAL_SYMBOLS, 8, 1'b1);

    // Random alphabets, mostly valid; the radix extremes come up often.
    while (sent_items < TOTAL_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: run_phase(5'($urandom_range(0, 1)), random_alphabet(16), 2, 1'b0);
          1: run_phase(5'($urandom_range(17, 31)), random_alphabet(16), 2, 1'b0);
          default: begin
            r = $urandom_range(2, 16);
            syms = spoil_alphabet(random_alphabet(r), r, $urandom_range(0, 1));
            run_phase(5'(r), syms, 2, 1'b0);
          end
        endcase
      end else begin
        if ($urandom_range(0, 3) == 0)
          r = ($urandom_range(0, 1) == 1) ? 2 : 16;
        else
          r = $urandom_range(2, 16);
        n = $urandom_range(6, 16);
        run_phase(5'(r), random_alphabet(r), n, $urandom_range(0, 3) == 0);
      end
    end

    if (text_check.errors == 0 && text_check.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sird_pkg.sv
design/sird_ctrl.sv
design/sird_dp.sv
design/signed_integer_to_radix_digits_core.sv
verif/tb_top.sv
